// File: hdl/pli_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
package pli_pkg;

  localparam int unsigned DataW         = 16;
  localparam int unsigned IdxW          = 4;
  localparam int unsigned CountW        = 5;
  localparam int unsigned DefMaxPoints  = 16;
  localparam int unsigned PointsReset   = 2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [IdxW-1:0]         point_index;
    logic signed [DataW-1:0] point_x;
    logic signed [DataW-1:0] point_y;
    logic signed [DataW-1:0] lookup_x;
  } pli_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] mapped_value;
    logic                    table_error;
  } pli_result_t;

  // Serial multiply-divide unit: quot = (mag_a * mag_b) / den.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] mag_a;
    logic [DataW-1:0] mag_b;
    logic [DataW-1:0] den;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
  } arith_rsp_t;

endpackage

// File: hdl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pli_arith.sv
// Bit-serial unsigned multiply followed by bit-serial restoring divide.
module pli_arith import pli_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DataW);
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]         phase_q, phase_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [2*DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0]   mcand_q, mcand_d;
  logic [DataW-1:0]   den_q, den_d;

  logic [DataW:0]     mul_sum;
  logic [DataW:0]     trial;
  logic [DataW:0]     trial_diff;
  logic               trial_ge;

  // Shift-add: multiplier sits in the low half and shifts out LSB first.
  assign mul_sum    = {1'b0, acc_q[2*DataW-1:DataW]}
                    + (acc_q[0] ? {1'b0, mcand_q} : {(DataW+1){1'b0}});
  // Restoring divide: one quotient bit enters at the bottom per step.
  assign trial      = acc_q[2*DataW-1:DataW-1];
  assign trial_diff = trial - {1'b0, den_q};
  assign trial_ge   = (trial >= {1'b0, den_q});

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    den_d   = den_q;
    unique case (phase_q)
      P_IDLE: begin
        if (req_i.start) begin
          acc_d   = {{DataW{1'b0}}, req_i.mag_b};
          mcand_d = req_i.mag_a;
          den_d   = req_i.den;
          cnt_d   = '0;
          phase_d = P_MUL;
        end
      end
      P_MUL: begin
        acc_d = {mul_sum, acc_q[DataW-1:1]};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == '1) begin
          phase_d = P_DIV;
        end
      end
      P_DIV: begin
        acc_d = {(trial_ge ? trial_diff[DataW-1:0] : trial[DataW-1:0]),
                 acc_q[DataW-2:0], trial_ge};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == '1) begin
          phase_d = P_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    den_q   <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q[DataW-1:0];

endmodule

// File: hdl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator top level: breakpoint table, serial search, serial mul/div.
// Write request: busy stays low, no result.
// Interpolated lookup: the n-entry table scan (n = breakpoints in use), then 16 multiply and
//   16 divide bit steps, before the done_o strobe; clamped and error answers skip the
//   multiply and divide, and too few points skip the scan as well. One lookup at a time.
// Results strobe for one cycle on done_o; the receiver cannot stall. Async active-low reset
//   clears control and sets points_in_use to 2; the breakpoint table is not cleared.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int unsigned MaxPoints = DefMaxPoints
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              start,
  output logic              busy,
  input  pli_req_t          req_i,
  // result channel
  output logic              done_o,
  output pli_result_t       result_o,
  // configuration: points_in_use
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned NW = $clog2(MaxPoints + 1);
  localparam int unsigned CW = (NW > CountW) ? NW : CountW;
  localparam int unsigned SW = AW + IdxW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_ARITH  = 2'd3;

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [CountW-1:0] points_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= CountW'(PointsReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      points_q <= cfg_data_i;
    end
  end

  // Effective point count, saturated at the table depth.
  logic [CW-1:0] points_ext;
  logic [CW-1:0] n_eff;

  assign points_ext = CW'(points_q);
  assign n_eff      = (points_ext > CW'(MaxPoints)) ? CW'(MaxPoints) : points_ext;

  // ---------------------------------------------------------------
  // Breakpoint table: x in the upper half, y in the lower half
  // ---------------------------------------------------------------
  logic [1:0]            state_q, state_d;
  logic                  accept;
  logic [SW-1:0]         slot;
  logic                  tbl_we;
  logic [AW-1:0]         tbl_raddr;
  logic [2*DataW-1:0]    tbl_rdata;
  logic signed [DataW-1:0] rx, ry;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign slot   = SW'(req_i.point_index);
  assign tbl_we = accept && (req_i.op == OP_WRITE) && (slot < SW'(MaxPoints));

  pli_ram #(
    .Width (2 * DataW),
    .Depth (MaxPoints)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot[AW-1:0]),
    .wdata_i ({req_i.point_x, req_i.point_y}),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign rx = $signed(tbl_rdata[2*DataW-1:DataW]);
  assign ry = $signed(tbl_rdata[DataW-1:0]);

  // ---------------------------------------------------------------
  // Lookup sequencer
  // ---------------------------------------------------------------
  logic [AW-1:0]           cur_q, cur_d;
  logic [AW-1:0]           last_idx_q, last_idx_d;
  logic                    found_q, found_d;
  logic                    dec_err_q, dec_err_d;
  logic                    below_q, below_d;
  logic                    dy_neg_q, dy_neg_d;
  logic                    den_zero_q, den_zero_d;
  logic                    done_q, done_d;
  logic signed [DataW-1:0] v_q, v_d;
  logic signed [DataW-1:0] px_q, px_d, py_q, py_d;
  logic signed [DataW-1:0] x0_q, x0_d, y0_q, y0_d;
  logic signed [DataW-1:0] x1_q, x1_d, y1_q, y1_d;
  logic signed [DataW-1:0] yfirst_q, yfirst_d;
  logic signed [DataW-1:0] xlast_q, xlast_d, ylast_q, ylast_d;
  logic signed [DataW-1:0] res_q, res_d;
  logic                    err_q, err_d;

  logic                    is_last;
  logic signed [DataW:0]   dy;
  logic [DataW:0]          dy_mag;
  arith_req_t              arith_req;
  arith_rsp_t              arith_rsp;

  assign is_last   = (cur_q == last_idx_q);
  assign tbl_raddr = (state_q == S_SCAN) ? (cur_q + AW'(1)) : '0;
  assign dy        = {y1_q[DataW-1], y1_q} - {y0_q[DataW-1], y0_q};
  assign dy_mag    = dy[DataW] ? (-dy) : dy;

  // Within a valid segment x0 <= v < x1, so both differences fit unsigned.
  assign arith_req.mag_a = dy_mag[DataW-1:0];
  assign arith_req.mag_b = v_q - x0_q;
  assign arith_req.den   = x1_q - x0_q;
  assign arith_req.start = (state_q == S_DECIDE) && !dec_err_q && !below_q
                         && (v_q < xlast_q);

  pli_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    last_idx_d = last_idx_q;
    found_d    = found_q;
    dec_err_d  = dec_err_q;
    below_d    = below_q;
    dy_neg_d   = dy_neg_q;
    den_zero_d = den_zero_q;
    done_d     = 1'b0;
    v_d        = v_q;
    px_d       = px_q;
    py_d       = py_q;
    x0_d       = x0_q;
    y0_d       = y0_q;
    x1_d       = x1_q;
    y1_d       = y1_q;
    yfirst_d   = yfirst_q;
    xlast_d    = xlast_q;
    ylast_d    = ylast_q;
    res_d      = res_q;
    err_d      = err_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_i.op == OP_LOOKUP)) begin
          if (n_eff < CW'(2)) begin
            res_d  = '0;
            err_d  = 1'b1;
            done_d = 1'b1;
          end else begin
            v_d        = req_i.lookup_x;
            cur_d      = '0;
            last_idx_d = AW'(n_eff - CW'(1));
            found_d    = 1'b0;
            dec_err_d  = 1'b0;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // table data here belongs to entry cur_q
        if (cur_q == '0) begin
          below_d  = (v_q <= rx);
          yfirst_d = ry;
        end else begin
          if (rx < px_q) begin
            dec_err_d = 1'b1;
          end
          // first breakpoint above v closes the segment, else the last one
          if (!found_q && ((rx > v_q) || is_last)) begin
            found_d = 1'b1;
            x0_d    = px_q;
            y0_d    = py_q;
            x1_d    = rx;
            y1_d    = ry;
          end
        end
        px_d = rx;
        py_d = ry;
        if (is_last) begin
          xlast_d = rx;
          ylast_d = ry;
          state_d = S_DECIDE;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      S_DECIDE: begin
        if (dec_err_q) begin
          res_d   = '0;
          err_d   = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (below_q) begin
          res_d   = yfirst_q;
          err_d   = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (v_q >= xlast_q) begin
          res_d   = ylast_q;
          err_d   = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          dy_neg_d   = dy[DataW];
          den_zero_d = (x1_q == x0_q);
          state_d    = S_ARITH;
        end
      end
      S_ARITH: begin
        if (arith_rsp.done) begin
          // truncation toward zero: divide magnitudes, then apply the sign
          if (den_zero_q) begin
            res_d = '0;
          end else if (dy_neg_q) begin
            res_d = y0_q - $signed(arith_rsp.quot);
          end else begin
            res_d = y0_q + $signed(arith_rsp.quot);
          end
          err_d   = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_q      <= '0;
      last_idx_q <= '0;
      found_q    <= 1'b0;
      dec_err_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      last_idx_q <= last_idx_d;
      found_q    <= found_d;
      dec_err_q  <= dec_err_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    below_q    <= below_d;
    dy_neg_q   <= dy_neg_d;
    den_zero_q <= den_zero_d;
    v_q        <= v_d;
    px_q       <= px_d;
    py_q       <= py_d;
    x0_q       <= x0_d;
    y0_q       <= y0_d;
    x1_q       <= x1_d;
    y1_q       <= y1_d;
    yfirst_q   <= yfirst_d;
    xlast_q    <= xlast_d;
    ylast_q    <= ylast_d;
    res_q      <= res_d;
    err_q      <= err_d;
  end

  assign done_o                = done_q;
  assign result_o.mapped_value = res_q;
  assign result_o.table_error  = err_q;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.table_error |-> result_o.mapped_value == '0)
    else $error("error result with nonzero value");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.op == OP_WRITE) |=> !done_o)
    else $error("write request produced a result");

  a_arith_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_rsp.done |-> state_q == S_ARITH)
    else $error("divider finished outside the wait state");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cur_q <= last_idx_q)
    else $error("scan index ran past the last breakpoint");

  a_arith_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ARITH && arith_rsp.done |=> done_o && state_q == S_IDLE)
    else $error("interpolation result not delivered");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the piecewise linear interpolator.
module tb import pli_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  pli_req_t          req_i;
  logic              done_o;
  pli_result_t       result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i;

  piecewise_linear_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the curve table and the points register. Updated on the edge a
  // request or register write is accepted, so it always matches what the DUT saw.
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] curve_x [DefMaxPoints];
  logic signed [DataW-1:0] curve_y [DefMaxPoints];
  logic [CountW-1:0]       points_cfg;

  pli_result_t pending_maps [$];   // expected lookup answers, oldest first
  pli_result_t want;
  int unsigned errors;
  int unsigned items_sent;
  bit          no_gaps;            // back-to-back requests when set

  // Expected answer of one lookup against the current shadow table.
  function automatic pli_result_t interpolate(logic signed [DataW-1:0] v);
    pli_result_t r;
    int unsigned n;
    int unsigned nxt;
    longint      x0, x1, y0, y1, acc;
    r = '0;
    // register values above the table depth saturate
    n = (points_cfg > DefMaxPoints) ? DefMaxPoints : points_cfg;
    if (n < 2) begin
      r.table_error = 1'b1;
      return r;
    end
    // any decreasing x in the used part of the table is an error
    for (int i = 0; i + 1 < n; i++) begin
      if (curve_x[i+1] < curve_x[i]) begin
        r.table_error = 1'b1;
        return r;
      end
    end
    if (v <= curve_x[0]) begin
      r.mapped_value = curve_y[0];
    end else if (v >= curve_x[n-1]) begin
      r.mapped_value = curve_y[n-1];
    end else begin
      // first breakpoint whose x exceeds v
      nxt = 1;
      while (nxt < n - 1 && curve_x[nxt] <= v) nxt++;
      x0 = curve_x[nxt-1];
      x1 = curve_x[nxt];
      y0 = curve_y[nxt-1];
      y1 = curve_y[nxt];
      if (x1 == x0) begin
        r.mapped_value = '0;
      end else begin
        // exact product, quotient truncated toward zero
        acc = y0 + ((y1 - y0) * (v - x0)) / (x1 - x0);
        r.mapped_value = DataW'(acc);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done_o strobe must match the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_maps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: value %0d error %0b", $time,
                 result_o.mapped_value, result_o.table_error);
      end else begin
        want = pending_maps.pop_front();
        if (result_o.mapped_value !== want.mapped_value) begin
          errors++;
          $display("%0t: mapped_value mismatch: expected %0d actual %0d", $time,
                   want.mapped_value, result_o.mapped_value);
        end
        if (result_o.table_error !== want.table_error) begin
          errors++;
          $display("%0t: table_error mismatch: expected %0b actual %0b", $time,
                   want.table_error, result_o.table_error);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. start stays high between back-to-back requests; it is
  // only lowered for a gap or by settle, so it never sees two NBAs in one step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input pli_req_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    // accepted on this edge
    if (r.op == OP_LOOKUP) begin
      pending_maps = {pending_maps, interpolate(r.lookup_x)};
    end else begin
      curve_x[r.point_index] = r.point_x;
      curve_y[r.point_index] = r.point_y;
    end
    items_sent++;
  endtask

  // Write request; the unused lookup field carries noise.
  task automatic write_point(input int unsigned slot, input int x, input int y);
    pli_req_t r;
    r.op          = OP_WRITE;
    r.point_index = IdxW'(slot);
    r.point_x     = DataW'(x);
    r.point_y     = DataW'(y);
    r.lookup_x    = DataW'($urandom);
    send_request(r);
  endtask

  // Lookup request; the unused write fields carry noise.
  task automatic lookup(input int v);
    pli_req_t r;
    r.op          = OP_LOOKUP;
    r.point_index = IdxW'($urandom);
    r.point_x     = DataW'($urandom);
    r.point_y     = DataW'($urandom);
    r.lookup_x    = DataW'(v);
    send_request(r);
  endtask

  // Hold off requests until every lookup has answered.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register write, only ever issued with the block idle.
  task automatic set_points(input int unsigned n);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CountW'(n);
    do @(posedge clk_i); while (!cfg_ready_o);
    points_cfg = cfg_data_i;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int clamp16(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Loads slots 0..n-1 with a sorted random curve; a broken curve gets one
  // decreasing step. Clustered x values give narrow and duplicate segments.
  task automatic load_curve(input int unsigned n, input bit broken);
    int          xs [$];
    int          base;
    int unsigned span;
    int unsigned k;
    bit          clustered;
    clustered = ($urandom_range(0, 3) == 0);
    base      = $urandom_range(0, 65535) - 32768;
    span      = $urandom_range(0, 64);
    for (int i = 0; i < n; i++) begin
      if (clustered) xs = {xs, clamp16(base + int'($urandom_range(0, span)))};
      else xs = {xs, int'($urandom_range(0, 65535)) - 32768};
    end
    xs.sort();
    if (broken) begin
      k = $urandom_range(0, n - 2);
      if (xs[k+1] < 32767) begin
        xs[k] = xs[k+1] + 1;
      end else begin
        xs[k]   = 32767;
        xs[k+1] = 32766;
      end
    end
    for (int i = 0; i < n; i++) begin
      write_point(i, xs[i], int'($urandom_range(0, 65535)) - 32768);
    end
  endtask

  // Lookup values aimed at segment interiors, breakpoints and the clamps.
  function automatic int pick_lookup_x(input int unsigned n);
    int          lo, hi;
    int unsigned i;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        i  = $urandom_range(0, n - 2);
        lo = curve_x[i];
        hi = curve_x[i+1];
        return (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
      end
      4, 5: return curve_x[$urandom_range(0, n - 1)];
      6:    return clamp16(curve_x[0] + int'($urandom_range(0, 2)) - 1);
      7:    return clamp16(curve_x[n-1] + int'($urandom_range(0, 2)) - 1);
      8:    return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full-range two-point curve at the reset setting of two breakpoints.
  // Every slot gets written here so no later lookup reads an empty slot.
  task automatic test_full_scale();
    write_point(0, -32768, 32767);
    write_point(1, 32767, -32768);
    for (int i = 2; i < DefMaxPoints; i++) write_point(i, 32767, int'($urandom_range(0, 65535)) - 32768);
    lookup(-32768);   // first x: clamps to first y
    lookup(32767);    // last x: clamps to last y
    lookup(0);        // middle of the x range
    lookup(1);
    lookup(-1);
    lookup(16384);
  endtask

  // Points register: too few, saturation above the table depth, the extremes.
  task automatic test_point_count();
    set_points(0);
    lookup(0);
    set_points(1);
    lookup(100);
    set_points(31);   // saturates to the full table
    lookup(-5);
    set_points(17);
    lookup(32767);
    set_points(DefMaxPoints);
    lookup(-32768);
  endtask

  // Decreasing x inside the used range errors; past the used range it is ignored.
  task automatic test_decreasing();
    set_points(3);
    write_point(2, -32768, 7);
    lookup(0);
    set_points(2);
    lookup(0);
  endtask

  // Duplicate x values: lookups on, between and around the repeated breakpoint.
  task automatic test_flat_step();
    set_points(4);
    write_point(0, 0, -1000);
    write_point(1, 100, 2000);
    write_point(2, 100, -3000);
    write_point(3, 200, 4000);
    lookup(100);
    lookup(50);
    lookup(150);
    lookup(-1);
  endtask

  // Random curves with random content, a share of broken ones and noise writes.
  task automatic test_random_curves();
    int unsigned cfg;
    int unsigned n;
    int unsigned count;
    while (items_sent < 1250) begin
      case ($urandom_range(0, 9))
        0:       cfg = $urandom_range(0, 1);
        1:       cfg = $urandom_range(17, 31);
        2:       cfg = DefMaxPoints;
        default: cfg = $urandom_range(2, DefMaxPoints);
      endcase
      no_gaps = 1'b0;
      set_points(cfg);
      n = (cfg > DefMaxPoints) ? DefMaxPoints : ((cfg < 2) ? 2 : cfg);
      no_gaps = ($urandom_range(0, 3) == 0);
      load_curve(n, $urandom_range(0, 6) == 0);
      count = $urandom_range(8, 30);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          write_point($urandom_range(0, DefMaxPoints - 1),
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768);
        end else begin
          lookup(pick_lookup_x(n));
        end
      end
      // occasional full drain without a register write
      if ($urandom_range(0, 4) == 0) settle();
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    points_cfg  = CountW'(PointsReset);
    errors      = 0;
    items_sent  = 0;
    no_gaps     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_full_scale();
    test_point_count();
    test_decreasing();
    test_flat_step();
    test_random_curves();

    // drain, then allow for a late extra strobe
    settle();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/pli_arith.sv
hdl/piecewise_linear_interpolator.sv
tb/tb.sv
